### rtl/sqm_pkg.sv
`timescale 1ns / 1ps

package sqm_pkg;

    typedef enum logic {
        FUNC_ARRIVAL = 1'b0,
        FUNC_TICK    = 1'b1
    } t_func;

    localparam int ID_W      = 16;
    localparam int TICK_W    = 32;
    localparam int SVC_W     = 8;
    localparam int QCNT_W    = 7;
    localparam int TOTAL_W   = 32;
    localparam int WSUM_W    = 48;

    localparam logic [SVC_W-1:0] SERVICE_RESET = 8'd3;

    typedef struct packed {
        t_func            func;
        logic [ID_W-1:0]  item_id;
    } t_in;

    typedef struct packed {
        logic               served;
        logic [ID_W-1:0]    served_id;
        logic [TICK_W-1:0]  served_wait;
        logic [QCNT_W-1:0]  queue_count;
        logic [QCNT_W-1:0]  max_count;
        logic [TOTAL_W-1:0] processed_total;
        logic [WSUM_W-1:0]  wait_total;
        logic               dropped;
    } t_out;

endpackage

### rtl/sqm_ram.sv
`timescale 1ns / 1ps

module sqm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/single_server_queue_monitor.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_stall     i_in_data   (t_in)
// out       output     o_out_valid / i_out_stall   o_out_data  (t_out)
// cfg       input      i_cfg_we                    i_cfg_wdata (service time)
//
// One transaction per cycle on each side while not stalled, one result per input transaction.
// Each transaction passes through the input register, then the result register.
// The queue head is prefetched from the entry RAM by the next head pointer,
// so back-to-back pops and pushes run at full rate.
// Synchronous active-low reset clears pointers, counters and valids.
// The input register absorbs one transaction while a result is stalled.

module single_server_queue_monitor
    import sqm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic [SVC_W-1:0] i_cfg_wdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] stamp;
    } t_entry;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    logic               r_in_valid;
    t_in                r_in;
    logic               r_out_valid;
    t_out               r_out, n_out;
    logic [SVC_W-1:0]   r_service;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [SVC_W-1:0]   r_busy, n_busy, busy_ld;
    logic [PTR_W-1:0]   r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]   r_occ, n_occ, r_hw, n_hw;
    logic [TOTAL_W-1:0] r_count, n_count;
    logic [WSUM_W-1:0]  r_wsum, n_wsum;
    logic [WSUM_W:0]    wsum_ext;
    logic               r_byp;
    t_entry             r_byp_data;
    t_entry             ram_rdata, head_ent, wr_data;
    logic               advance, fire, full, pop, wr_en;
    logic [TICK_W-1:0]  swait;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    assign head_ent = r_byp ? r_byp_data : ram_rdata;
    assign wr_data  = '{id: r_in.item_id, stamp: r_tick};
    assign full     = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign swait    = r_tick - head_ent.stamp;
    assign wsum_ext = {1'b0, r_wsum} + (WSUM_W + 1)'(swait);

    sqm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_tail),
        .i_wdata (wr_data),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        n_hw    = r_hw;
        n_tick  = r_tick;
        n_busy  = r_busy;
        n_count = r_count;
        n_wsum  = r_wsum;
        n_out   = r_out;
        wr_en   = 1'b0;
        pop     = 1'b0;
        busy_ld = r_busy;
        if (fire) begin
            n_out = '0;
            case (r_in.func)
                FUNC_ARRIVAL: begin
                    if (full) begin
                        n_out.dropped = 1'b1;
                    end else begin
                        wr_en  = 1'b1;
                        n_tail = next_slot(r_tail);
                        n_occ  = r_occ + CNT_W'(1);
                        if (n_occ > r_hw) begin
                            n_hw = n_occ;
                        end
                    end
                end
                FUNC_TICK: begin
                    pop = (r_busy == '0) && (r_occ != '0);
                    if (pop) begin
                        n_head = next_slot(r_head);
                        n_occ  = r_occ - CNT_W'(1);
                        if (r_count != '1) begin
                            n_count = r_count + TOTAL_W'(1);
                        end
                        n_wsum  = wsum_ext[WSUM_W] ? '1 : wsum_ext[WSUM_W-1:0];
                        busy_ld = r_service;
                        n_out.served      = 1'b1;
                        n_out.served_id   = head_ent.id;
                        n_out.served_wait = swait;
                    end
                    n_busy = (busy_ld != '0) ? busy_ld - SVC_W'(1) : busy_ld;
                    n_tick = r_tick + TICK_W'(1);
                end
                default: ;
            endcase
            n_out.queue_count     = QCNT_W'(n_occ);
            n_out.max_count       = QCNT_W'(n_hw);
            n_out.processed_total = n_count;
            n_out.wait_total      = n_wsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_service   <= SERVICE_RESET;
            r_tick      <= '0;
            r_busy      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_hw        <= '0;
            r_count     <= '0;
            r_wsum      <= '0;
            r_byp       <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_service <= i_cfg_wdata;
            end
            r_tick  <= n_tick;
            r_busy  <= n_busy;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_hw    <= n_hw;
            r_count <= n_count;
            r_wsum  <= n_wsum;
            r_byp   <= wr_en && (r_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        r_out      <= n_out;
        r_byp_data <= wr_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw >= r_occ)
        else $error("high-water mark below occupancy");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == ((r_occ == '0) || (r_occ == CNT_W'(QUEUE_DEPTH))))
        else $error("pointers disagree with occupancy");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench
    import sqm_pkg::*;
();

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    class queue_scoreboard;
        logic [SVC_W-1:0]   service_ticks;
        logic [TICK_W-1:0]  tick_now;
        logic [SVC_W-1:0]   busy_left;
        logic [ID_W-1:0]    slot_id [DEPTH];
        logic [TICK_W-1:0]  slot_stamp [DEPTH];
        logic [5:0]         head;
        logic [5:0]         tail;
        logic [QCNT_W-1:0]  occupancy;
        logic [QCNT_W-1:0]  high_water;
        logic [TOTAL_W-1:0] served_cnt;
        logic [WSUM_W-1:0]  wait_sum;
        t_out               pending_reports [$];
        int                 err_cnt;

        function new();
            service_ticks = SERVICE_RESET;
            tick_now      = '0;
            busy_left     = '0;
            head          = '0;
            tail          = '0;
            occupancy     = '0;
            high_water    = '0;
            served_cnt    = '0;
            wait_sum      = '0;
            err_cnt       = 0;
        endfunction

        function void note_input_txn(t_in txn);
            t_out rpt;
            logic [TICK_W-1:0] wait_ticks;
            rpt = '0;
            if (txn.func == FUNC_ARRIVAL) begin
                if (occupancy >= QCNT_W'(DEPTH)) begin
                    rpt.dropped = 1'b1;
                end else begin
                    slot_id[tail]    = txn.item_id;
                    slot_stamp[tail] = tick_now;
                    tail             = tail + 6'd1;
                    occupancy        = occupancy + QCNT_W'(1);
                    if (occupancy > high_water) begin
                        high_water = occupancy;
                    end
                end
            end else begin
                if (busy_left == 0 && occupancy != 0) begin
                    wait_ticks      = tick_now - slot_stamp[head];
                    rpt.served      = 1'b1;
                    rpt.served_id   = slot_id[head];
                    rpt.served_wait = wait_ticks;
                    head            = head + 6'd1;
                    occupancy       = occupancy - QCNT_W'(1);
                    if (served_cnt != '1) begin
                        served_cnt = served_cnt + TOTAL_W'(1);
                    end
                    if ({WSUM_W{1'b1}} - wait_sum < {16'b0, wait_ticks}) begin
                        wait_sum = '1;
                    end else begin
                        wait_sum = wait_sum + WSUM_W'(wait_ticks);
                    end
                    busy_left = service_ticks;
                end
                if (busy_left != 0) begin
                    busy_left = busy_left - SVC_W'(1);
                end
                tick_now = tick_now + TICK_W'(1);
            end
            rpt.queue_count     = occupancy;
            rpt.max_count       = high_water;
            rpt.processed_total = served_cnt;
            rpt.wait_total      = wait_sum;
            pending_reports.push_back(rpt);
        endfunction

        function void compare_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                err_cnt++;
            end
        endfunction

        function void check_report(t_out got);
            t_out want;
            if (pending_reports.size() == 0) begin
                $error("result transaction with nothing expected");
                err_cnt++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("served", 48'(want.served), 48'(got.served));
            compare_field("served_id", 48'(want.served_id), 48'(got.served_id));
            compare_field("served_wait", 48'(want.served_wait), 48'(got.served_wait));
            compare_field("queue_count", 48'(want.queue_count), 48'(got.queue_count));
            compare_field("max_count", 48'(want.max_count), 48'(got.max_count));
            compare_field("processed_total", 48'(want.processed_total),
                          48'(got.processed_total));
            compare_field("wait_total", want.wait_total, got.wait_total);
            compare_field("dropped", 48'(want.dropped), 48'(got.dropped));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic [SVC_W-1:0] i_cfg_wdata;

    queue_scoreboard sb;
    int              in_idle_pct;
    int              out_idle_pct;
    bit              hold_req;
    int              hold_left;
    int              cycle_cnt;

    single_server_queue_monitor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check accepted transactions, then pick next stall
    initial begin
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_report(o_out_data);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    function automatic t_in make_txn(t_func f, logic [ID_W-1:0] id);
        t_in txn;
        txn.func    = f;
        txn.item_id = id;
        return txn;
    endfunction

    task automatic send_txn(input t_in txn);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= txn;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.note_input_txn(txn);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_service(input logic [SVC_W-1:0] ticks);
        drain_results();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        sb.service_ticks = ticks;
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_txn, input int arrival_pct);
        t_func f;
        for (int k = 0; k < n_txn; k++) begin
            f = ($urandom_range(99) < arrival_pct) ? FUNC_ARRIVAL : FUNC_TICK;
            send_txn(make_txn(f, ID_W'($urandom)));
            if ($urandom_range(39) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        sb           = new();
        cycle_cnt    = 0;
        hold_req     = 1'b0;
        in_idle_pct  = 15;
        out_idle_pct = 65;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default service time: empty tick, zero wait, busy server
        send_txn(make_txn(FUNC_TICK, 16'h0000));
        send_txn(make_txn(FUNC_ARRIVAL, 16'h0000));
        send_txn(make_txn(FUNC_TICK, 16'h0000));
        send_txn(make_txn(FUNC_ARRIVAL, 16'hFFFF));
        send_txn(make_txn(FUNC_ARRIVAL, 16'hA5A5));
        for (int k = 0; k < 4; k++) send_txn(make_txn(FUNC_TICK, 16'hFFFF));
        send_txn(make_txn(FUNC_ARRIVAL, 16'h5A5A));
        for (int k = 0; k < 7; k++) send_txn(make_txn(FUNC_TICK, 16'h0000));

        // zero service time: one pop per tick
        write_service(8'd0);
        send_txn(make_txn(FUNC_ARRIVAL, 16'h1234));
        send_txn(make_txn(FUNC_ARRIVAL, 16'hEDCB));
        for (int k = 0; k < 3; k++) send_txn(make_txn(FUNC_TICK, 16'h0000));

        // longest service: fill the queue past full under a long output hold
        write_service(8'd255);
        hold_req = 1'b1;
        for (int k = 0; k < DEPTH + 3; k++) begin
            send_txn(make_txn(FUNC_ARRIVAL, ID_W'($urandom)));
        end
        for (int k = 0; k < 4; k++) send_txn(make_txn(FUNC_TICK, ID_W'($urandom)));

        write_service(8'd1);
        random_phase(130, 35);

        in_idle_pct  = 65;
        out_idle_pct = 15;
        write_service(SVC_W'($urandom_range(2, 6)));
        random_phase(120, 55);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_service(SVC_W'($urandom_range(1, 255)));
        random_phase(60, 70);
        write_service(8'd3);
        random_phase(60, 45);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.pending_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### single_server_queue_monitor.f
rtl/sqm_pkg.sv
rtl/sqm_ram.sv
rtl/single_server_queue_monitor.sv
sim/testbench.sv
